/* rtl/swid_pkg.sv */
// Shared types and constants for the sync word image deframer.
// Used by swid_clip and the top level sync_word_image_deframer; no dependencies.
`default_nettype none
package swid_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h7A;
	localparam int HEADER_BYTES = 24;
	localparam int HEADER_WORDS = 6;
	localparam int HDR_IDX_W = 5;
	localparam int WORD_IDX_W = 3;
	localparam int CAP_W = 25;
	localparam int COUNT_W = 31;
	localparam int DATA_W = 208;
	localparam logic [CAP_W-1:0] CAP_RESET = 25'd4194304;

	localparam int SYNC_LENGTH_DEF = 64;
	localparam int HEADROOM_WORDS_DEF = 1024;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// Index of the pixel count among the header words.
	localparam int COUNT_WORD = 2;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_HEADER = 3'b010,
		PH_PIXELS = 3'b100
	} phase_t;

	typedef struct packed {
		logic clipped;
		logic [COUNT_W-1:0] count;
	} clip_res_t;

endpackage
`default_nettype wire

/* rtl/swid_clip.sv */
// Pixel count clipping against the capacity register.
// Depends on swid_pkg for widths and the clip result struct.
`default_nettype none
module swid_clip #(
	parameter int HEADROOM_WORDS = swid_pkg::HEADROOM_WORDS_DEF
) (
	input wire logic [31:0] count_word,
	input wire logic [swid_pkg::CAP_W-1:0] capacity,
	output swid_pkg::clip_res_t res
);

	logic signed [33:0] n_ext;
	logic signed [33:0] cap_ext;
	logic signed [33:0] cut;
	logic signed [33:0] eff;
	logic over;

	always_comb begin
		n_ext = 34'(signed'(count_word));
		cap_ext = signed'({9'd0, capacity});
		cut = cap_ext - 34'(HEADROOM_WORDS);
		// The count word is signed; the capacity is never negative.
		over = n_ext > cap_ext;
		eff = over ? cut : n_ext;
		res.clipped = over;
		res.count = (eff > 34'sd0) ? eff[swid_pkg::COUNT_W-1:0] : '0;
	end

endmodule
`default_nettype wire

/* rtl/sync_word_image_deframer.sv */
// Sync word image deframer: one byte per word in, header and pixel words out.
// A result reaches the master side in the cycle after the byte that completes it.
// One byte per clock is taken while the output register is empty or being drained.
// arst_n clears the phase, counters and output valid; capacity resets to 4194304.
// Depends on swid_pkg and swid_clip.
`default_nettype none
module sync_word_image_deframer #(
	parameter int SYNC_LENGTH = swid_pkg::SYNC_LENGTH_DEF,
	parameter int HEADROOM_WORDS = swid_pkg::HEADROOM_WORDS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // data_byte[7:0]
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// size_x[31:0], size_y[63:32], pixel_count[94:64], camera_frame[126:95],
	// software_count[158:127], error_word[190:159], clipped[191], pixel_value[207:192]
	output logic [swid_pkg::DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast,
	output logic m_axis_tuser, // kind
	input wire logic cfg_we,
	input wire logic [swid_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int RunW = $clog2(SYNC_LENGTH + 1);

	swid_pkg::phase_t phase_q, phase_d;
	logic [RunW-1:0] run_q, run_d, run_inc;
	logic [swid_pkg::HDR_IDX_W-1:0] hdr_idx_q, hdr_idx_d;
	logic [31:0] hw_q [swid_pkg::HEADER_WORDS];
	logic [7:0] low_q;
	logic byte_ph_q, byte_ph_d;
	logic [swid_pkg::COUNT_W-1:0] left_q, left_d, left_dec;
	logic [swid_pkg::CAP_W-1:0] cap_q;

	logic m_valid_q;
	logic [swid_pkg::DATA_W-1:0] data_q;
	logic last_q;
	logic kind_q;

	logic s_fire;
	logic hdr_done;
	logic res_valid;
	logic res_last;
	logic res_kind;
	logic [swid_pkg::DATA_W-1:0] res_data;
	logic [swid_pkg::WORD_IDX_W-1:0] wsel;
	swid_pkg::clip_res_t clip;

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign wsel = hdr_idx_q[swid_pkg::HDR_IDX_W-1:2];
	assign hdr_done = hdr_idx_q == swid_pkg::HDR_IDX_W'(swid_pkg::HEADER_BYTES - 1);
	assign run_inc = run_q + RunW'(1);
	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

	swid_clip #(
		.HEADROOM_WORDS(HEADROOM_WORDS)
	) u_clip (
		.count_word(hw_q[swid_pkg::COUNT_WORD]),
		.capacity(cap_q),
		.res(clip)
	);

	always_comb begin
		phase_d = phase_q;
		run_d = run_q;
		hdr_idx_d = hdr_idx_q;
		byte_ph_d = byte_ph_q;
		left_d = left_q;
		res_valid = 1'b0;
		res_last = 1'b0;
		res_kind = swid_pkg::KIND_HEADER;
		res_data = '0;
		case (phase_q)
			swid_pkg::PH_HEADER: begin
				if (hdr_done) begin
					hdr_idx_d = '0;
					res_valid = 1'b1;
					// The final header byte is the top byte of the error word.
					res_data = {16'd0, clip.clipped, s_axis_tdata, hw_q[5][23:0], hw_q[4],
						hw_q[3], clip.count, hw_q[1], hw_q[0]};
					if (clip.count == '0) begin
						res_last = 1'b1;
						phase_d = swid_pkg::PH_HUNT;
						run_d = '0;
					end else begin
						left_d = clip.count;
						byte_ph_d = 1'b0;
						phase_d = swid_pkg::PH_PIXELS;
					end
				end else begin
					hdr_idx_d = hdr_idx_q + 1'b1;
				end
			end
			swid_pkg::PH_PIXELS: begin
				byte_ph_d = !byte_ph_q;
				if (byte_ph_q) begin
					res_valid = 1'b1;
					res_kind = swid_pkg::KIND_PIXEL;
					res_data = {s_axis_tdata, low_q, 192'd0};
					left_d = left_dec;
					if (left_dec == '0) begin
						res_last = 1'b1;
						phase_d = swid_pkg::PH_HUNT;
						run_d = '0;
					end
				end
			end
			default: begin
				phase_d = swid_pkg::PH_HUNT;
				if (s_axis_tdata == swid_pkg::SYNC_BYTE) begin
					if (run_inc >= RunW'(SYNC_LENGTH)) begin
						run_d = '0;
						hdr_idx_d = '0;
						phase_d = swid_pkg::PH_HEADER;
					end else begin
						run_d = run_inc;
					end
				end else begin
					run_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swid_pkg::PH_HUNT;
			run_q <= '0;
			hdr_idx_q <= '0;
			byte_ph_q <= 1'b0;
			left_q <= '0;
			cap_q <= swid_pkg::CAP_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (s_fire) begin
				phase_q <= phase_d;
				run_q <= run_d;
				hdr_idx_q <= hdr_idx_d;
				byte_ph_q <= byte_ph_d;
				left_q <= left_d;
				m_valid_q <= res_valid;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Header bytes land in their word lane; pixel low bytes wait for their partner.
	always_ff @(posedge clk) begin
		if (s_fire && phase_q == swid_pkg::PH_HEADER) begin
			hw_q[wsel][8*hdr_idx_q[1:0] +: 8] <= s_axis_tdata;
		end
		if (s_fire && phase_q == swid_pkg::PH_PIXELS && !byte_ph_q) begin
			low_q <= s_axis_tdata;
		end
		if (s_fire && res_valid) begin
			data_q <= res_data;
			last_q <= res_last;
			kind_q <= res_kind;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = data_q;
	assign m_axis_tlast = last_q;
	assign m_axis_tuser = kind_q;

`ifndef SYNTHESIS
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == swid_pkg::KIND_HEADER
		|-> m_axis_tlast == (m_axis_tdata[94:64] == '0))
		else $error("header word last flag disagrees with its pixel count");
	a_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != swid_pkg::PH_HUNT |-> run_q == '0)
		else $error("sync run counter not cleared outside the hunt");
	a_last_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && res_valid && res_last |=> phase_q == swid_pkg::PH_HUNT)
		else $error("frame ended but deframer did not return to hunting");
	a_pix_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == swid_pkg::PH_PIXELS |-> left_q != '0)
		else $error("pixel phase entered with no pixels left");
`endif

endmodule
`default_nettype wire

/* tb/tb_sync_word_image_deframer.sv */
// Self-checking testbench for sync_word_image_deframer: drives a byte stream of sync runs,
// headers, pixels and noise, predicts every header and pixel word, and checks them in order.
// Depends on swid_pkg and the sync_word_image_deframer RTL.
`timescale 1ns / 100ps

module tb_sync_word_image_deframer;
	import swid_pkg::*;

	localparam int SYNC_LEN = SYNC_LENGTH_DEF;
	localparam int HEADROOM = HEADROOM_WORDS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TOTAL_BYTES = 1100;

	// Same layout as the master-side tdata, lowest field last.
	typedef struct packed {
		logic [15:0] pixel_value;
		logic clipped;
		logic [31:0] error_word;
		logic [31:0] software_count;
		logic [31:0] camera_frame;
		logic [COUNT_W-1:0] pixel_count;
		logic [31:0] size_y;
		logic [31:0] size_x;
	} frame_word_t;

	typedef struct {
		logic kind;
		logic last;
		frame_word_t f;
	} frame_result_t;

	class deframe_board;
		typedef enum {SEEK, HEAD, PIXELS} stage_e;

		stage_e stage;
		int unsigned run;
		int unsigned hidx;
		logic [31:0] words [HEADER_WORDS];
		logic [7:0] low_hold;
		bit odd;
		logic [COUNT_W-1:0] left;
		logic [CAP_W-1:0] cap;
		frame_result_t pending_q [$];
		int errors;
		int headers;
		int pixels;
		int clips;
		int short_frames;

		function new();
			stage = SEEK;
			run = 0;
			hidx = 0;
			low_hold = '0;
			odd = 0;
			left = '0;
			cap = CAP_RESET;
			errors = 0;
			headers = 0;
			pixels = 0;
			clips = 0;
			short_frames = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] v);
			cap = v;
		endfunction

		function bit in_pixels();
			return stage == PIXELS;
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 10) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		function void check_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				fail($sformatf("%s expected %h, got %h", name, e, a));
			end
		endfunction

		// Advance the frame state by one accepted byte and queue any word it completes.
		function void note_byte(logic [7:0] b);
			frame_result_t r;
			longint n;
			logic clip;
			int w;
			int sh;
			r.kind = KIND_HEADER;
			r.last = 1'b0;
			r.f = '0;
			case (stage)
				HEAD: begin
					w = hidx / 4;
					sh = (hidx % 4) * 8;
					if (sh == 0) begin
						words[w] = '0;
					end
					words[w][sh +: 8] = b;
					hidx++;
					if (hidx == HEADER_BYTES) begin
						hidx = 0;
						// The count is signed; the capacity is compared as a non-negative number.
						n = longint'($signed(words[COUNT_WORD]));
						clip = 1'b0;
						if (n > longint'(cap)) begin
							n = longint'(cap) - HEADROOM;
							clip = 1'b1;
						end
						if (n < 0) begin
							n = 0;
						end
						r.f.size_x = words[0];
						r.f.size_y = words[1];
						r.f.pixel_count = n[COUNT_W-1:0];
						r.f.camera_frame = words[3];
						r.f.software_count = words[4];
						r.f.error_word = words[5];
						r.f.clipped = clip;
						r.last = (n == 0);
						if (n == 0) begin
							stage = SEEK;
							run = 0;
							short_frames++;
						end else begin
							left = n[COUNT_W-1:0];
							odd = 0;
							stage = PIXELS;
						end
						headers++;
						if (clip) begin
							clips++;
						end
						pending_q.push_back(r);
					end
				end
				PIXELS: begin
					if (!odd) begin
						low_hold = b;
						odd = 1;
					end else begin
						odd = 0;
						r.kind = KIND_PIXEL;
						r.f.pixel_value = {b, low_hold};
						if (left > 0) begin
							left--;
						end
						if (left == 0) begin
							r.last = 1'b1;
							stage = SEEK;
							run = 0;
						end
						pixels++;
						pending_q.push_back(r);
					end
				end
				default: begin
					if (b == SYNC_BYTE) begin
						run = (run + 1) & 7'h7F;
						if (run >= SYNC_LEN) begin
							run = 0;
							hidx = 0;
							stage = HEAD;
						end
					end else begin
						run = 0;
					end
				end
			endcase
		endfunction

		function void check_word(frame_word_t a, logic last, logic kind);
			frame_result_t e;
			if (pending_q.size() == 0) begin
				fail($sformatf("unexpected word kind %b last %b data %h", kind, last, a));
				return;
			end
			e = pending_q.pop_front();
			check_field("kind", e.kind, kind);
			check_field("last", e.last, last);
			check_field("size_x", e.f.size_x, a.size_x);
			check_field("size_y", e.f.size_y, a.size_y);
			check_field("pixel_count", e.f.pixel_count, a.pixel_count);
			check_field("camera_frame", e.f.camera_frame, a.camera_frame);
			check_field("software_count", e.f.software_count, a.software_count);
			check_field("error_word", e.f.error_word, a.error_word);
			check_field("clipped", e.f.clipped, a.clipped);
			check_field("pixel_value", e.f.pixel_value, a.pixel_value);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	deframe_board board;
	bit steady = 0;
	int bytes_sent = 0;
	int caps_used = 0;
	int cycles = 0;

	sync_word_image_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_word(frame_word_t'(m_axis_tdata), m_axis_tlast, m_axis_tuser);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timed out after %0d cycles with %0d words outstanding", cycles,
			board.outstanding());
		$display("RESULT: ERROR");
		$finish;
	end

	// Valid is left high after a word so that back-to-back words need no second assignment.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (!steady && $urandom_range(0, 99) < 25) begin
			gap = $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		board.note_byte(b);
		bytes_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_capacity(v);
		caps_used++;
	endtask

	// Sync run, header, then pixel bytes for as long as the frame asks for them.
	task automatic send_frame(input logic [191:0] hdr, input bit hold, input bit ramp);
		int j;
		for (j = 0; j < SYNC_LEN; j++) begin
			push_byte(SYNC_BYTE);
		end
		for (j = 0; j < HEADER_BYTES; j++) begin
			push_byte(hdr[8*j +: 8]);
		end
		if (hold) begin
			drain();
		end
		j = 0;
		while (board.in_pixels()) begin
			push_byte(ramp ? ((((j / 2) % 2) != 0) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
			j++;
		end
	endtask

	// Random bytes, sometimes after a sync run that falls short; the random bytes never
	// carry the sync byte, so the short run can never grow into a full one.
	task automatic send_noise();
		int n;
		int k;
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, SYNC_LEN - 1);
			for (k = 0; k < n; k++) begin
				push_byte(SYNC_BYTE);
			end
		end
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			b = 8'($urandom);
			if (b == SYNC_BYTE) begin
				b = ~b;
			end
			push_byte(b);
		end
	endtask

	function automatic logic [191:0] make_header(logic [31:0] sx, logic [31:0] sy,
			logic [31:0] cnt, logic [31:0] cam, logic [31:0] sw, logic [31:0] err);
		return {err, sw, cam, cnt, sy, sx};
	endfunction

	function automatic logic [CAP_W-1:0] pick_capacity();
		case ($urandom_range(0, 7))
			0: return CAP_RESET;
			1: return 25'd1025;
			2: return 25'd16777216;
			3: return 25'h1FF_FFFF;
			4: return 25'd0;
			5: return 25'd1024;
			6: return 25'(HEADROOM + $urandom_range(1, 12));
			default: return 25'($urandom_range(1041, 33554431));
		endcase
	endfunction

	// Counts above the capacity are only used when the clipped count stays small.
	function automatic logic [31:0] pick_count(logic [CAP_W-1:0] cap);
		bit tight;
		tight = (cap <= HEADROOM + 16);
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return {1'b1, 31'($urandom)};
			2: return tight ? 32'h7FFF_FFFF : 32'd1;
			3: return tight ? 32'(cap) + 32'd1 : 32'($urandom_range(1, 8));
			default: return 32'($urandom_range(1, 8));
		endcase
	endfunction

	initial begin
		int ph;
		int nframes;
		int f;
		logic [31:0] sx;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset capacity: field extremes, pixels of all zeros and all ones,
		// and a pause mid-frame until the header word has come out.
		send_frame(make_header(32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'hFFFF_FFFF, 32'h0,
			32'h8000_0000), 1, 1);
		// A sync run longer than needed: the extra sync bytes land in the x size.
		send_frame(make_header(32'h7A7A_7A7A, 32'h0, 32'd0, 32'h0, 32'hFFFF_FFFF,
			32'h7FFF_FFFF), 0, 0);
		send_frame(make_header(32'h1, 32'h2, 32'h8000_0000, 32'h3, 32'h4, 32'h5), 0, 0);
		// A run one short of the sync length, broken by another byte.
		for (f = 0; f < SYNC_LEN - 1; f++) begin
			push_byte(SYNC_BYTE);
		end
		push_byte(8'h79);
		send_frame(make_header(32'h0, 32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0), 0, 0);
		write_capacity(25'd1025);
		send_frame(make_header(32'd640, 32'd480, 32'h7FFF_FFFF, 32'd7, 32'd8, 32'd0), 0, 1);
		write_capacity(25'd1024);
		send_frame(make_header(32'd16, 32'd16, 32'd5, 32'd1, 32'd2, 32'd3), 0, 0);
		write_capacity(25'd0);
		send_frame(make_header(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1), 0, 0);
		write_capacity(25'h1FF_FFFF);
		send_frame(make_header(32'd2, 32'd1, 32'd2, 32'd9, 32'd9, 32'd9), 0, 1);
		write_capacity(25'd16777216);
		send_frame(make_header(32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0), 0, 0);

		// The first random pass runs with no random idling on either side.
		ph = 0;
		while (bytes_sent < TOTAL_BYTES) begin
			steady = (ph == 0);
			write_capacity(pick_capacity());
			nframes = $urandom_range(1, 3);
			for (f = 0; f < nframes; f++) begin
				send_noise();
				sx = $urandom;
				if ($urandom_range(0, 4) == 0) begin
					sx[7:0] = SYNC_BYTE;
				end
				send_frame(make_header(sx, $urandom, pick_count(board.cap), $urandom, $urandom,
					$urandom), $urandom_range(0, 7) == 0, 0);
			end
			ph++;
		end
		steady = 0;

		s_axis_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d headers (%0d ended the frame, %0d clipped) and %0d pixels",
			board.headers, board.short_frames, board.clips, board.pixels);
		$display("from %0d bytes over %0d capacity settings; %0d mismatches.",
			bytes_sent, caps_used, board.errors);
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
